>>> rtl/segment_plane_intersection_macros.svh
// Assertion macros for the segment/plane intersection block
`ifndef SEGMENT_PLANE_INTERSECTION_MACROS_SVH
`define SEGMENT_PLANE_INTERSECTION_MACROS_SVH

// implication checked on every clock edge outside reset
`define SPI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define SPI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/spi_pkg.sv
// Package for the segment/plane intersection block: widths and codes
package spi_pkg;
  localparam int COORD_WIDTH = 32;
  localparam int NORM_WIDTH  = 18;
  localparam int OFF_WIDTH   = 32;
  localparam int FRAC_WIDTH  = 17;
  localparam int FRAC_BITS   = 16;
  localparam int CFG_IDX_WIDTH = 2;
  // r = p2 - p1
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  // product of a coord and the normal, floored by 2^16
  localparam int PROD_WIDTH  = DIFF_WIDTH + NORM_WIDTH;
  // sums of three products plus offset
  localparam int SUM_WIDTH   = PROD_WIDTH + 3;
  localparam int DIV_STAGES  = 16;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_NORMAL_X     = 2'd0,
    REG_NORMAL_Y     = 2'd1,
    REG_NORMAL_Z     = 2'd2,
    REG_PLANE_OFFSET = 2'd3
  } cfg_reg_t;

  typedef logic signed [SUM_WIDTH-1:0] sum_t;
endpackage

>>> rtl/segment_plane_intersection.sv
// Top level: pipelined segment/plane intersection
// channel | direction | request handshake
// in_*    | input     | in_valid / in_ready
// out_*   | output    | out_valid / out_ready
// cfg_*   | input     | cfg_wr_en, no wait
// One request per cycle while not stalled; the depth is set mostly by the
// restoring divider (one quotient bit per stage; t = 1 is flagged before it).
// Stages: product, sums, sign fix/check, 16 divider stages, 3 point stages,
// saturate/output. The whole pipeline advances only when the output
// register is free or being taken, so a stall holds every stage.
// Reset (synchronous, rst_n low) clears valid bits and the plane registers, but sets normal z to 65536.
`include "segment_plane_intersection_macros.svh"
module segment_plane_intersection (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [spi_pkg::COORD_WIDTH-1:0] in_start_x,
  input  logic signed [spi_pkg::COORD_WIDTH-1:0] in_start_y,
  input  logic signed [spi_pkg::COORD_WIDTH-1:0] in_start_z,
  input  logic signed [spi_pkg::COORD_WIDTH-1:0] in_end_x,
  input  logic signed [spi_pkg::COORD_WIDTH-1:0] in_end_y,
  input  logic signed [spi_pkg::COORD_WIDTH-1:0] in_end_z,
  output logic out_valid,
  input  logic out_ready,
  output logic out_hit,
  output logic [spi_pkg::FRAC_WIDTH-1:0] out_fraction,
  output logic signed [spi_pkg::COORD_WIDTH-1:0] out_point_x,
  output logic signed [spi_pkg::COORD_WIDTH-1:0] out_point_y,
  output logic signed [spi_pkg::COORD_WIDTH-1:0] out_point_z,
  input  logic cfg_wr_en,
  input  logic [spi_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [spi_pkg::OFF_WIDTH-1:0] cfg_data
);
  localparam int CW = spi_pkg::COORD_WIDTH;
  localparam int DW = spi_pkg::DIFF_WIDTH;
  localparam int PW = spi_pkg::PROD_WIDTH;
  localparam int SW = spi_pkg::SUM_WIDTH;
  localparam int NW = spi_pkg::NORM_WIDTH;
  localparam int FW = spi_pkg::FRAC_WIDTH;
  localparam int FB = spi_pkg::FRAC_BITS;
  localparam int ND = spi_pkg::DIV_STAGES;
  // r*frac product width
  localparam int MW = DW + FW + 1;
  localparam int PTW = MW + 1;

  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // plane registers
  logic signed [NW-1:0] nx_r, ny_r, nz_r;
  logic signed [spi_pkg::OFF_WIDTH-1:0] off_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r  <= '0;
      ny_r  <= '0;
      nz_r  <= NW'(65536);
      off_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (spi_pkg::cfg_reg_t'(cfg_index))
        spi_pkg::REG_NORMAL_X:     nx_r  <= cfg_data[NW-1:0];
        spi_pkg::REG_NORMAL_Y:     ny_r  <= cfg_data[NW-1:0];
        spi_pkg::REG_NORMAL_Z:     nz_r  <= cfg_data[NW-1:0];
        spi_pkg::REG_PLANE_OFFSET: off_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: differences and the six floored products
  logic s1_v_r;
  logic signed [CW-1:0] s1_p_r [3];
  logic signed [DW-1:0] s1_d_r [3];
  logic signed [PW-1:0] s1_pn_r [3], s1_rn_r [3];
  logic signed [CW-1:0] pin [3], ein [3];
  assign pin[0] = in_start_x; assign pin[1] = in_start_y; assign pin[2] = in_start_z;
  assign ein[0] = in_end_x;   assign ein[1] = in_end_y;   assign ein[2] = in_end_z;
  logic signed [NW-1:0] nv [3];
  assign nv[0] = nx_r; assign nv[1] = ny_r; assign nv[2] = nz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (advance) s1_v_r <= in_valid;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        s1_p_r[i]  <= pin[i];
        s1_d_r[i]  <= DW'(ein[i]) - DW'(pin[i]);
        // arithmetic shift floors the product
        s1_pn_r[i] <= PW'((DW'(pin[i]) * nv[i]) >>> FB);
        s1_rn_r[i] <= PW'(((DW'(ein[i]) - DW'(pin[i])) * nv[i]) >>> FB);
      end
    end
  end

  // stage 2: num and den
  logic s2_v_r;
  logic signed [CW-1:0] s2_p_r [3];
  logic signed [DW-1:0] s2_d_r [3];
  spi_pkg::sum_t s2_num_r, s2_den_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (advance) s2_v_r <= s1_v_r;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      s2_p_r   <= s1_p_r;
      s2_d_r   <= s1_d_r;
      s2_num_r <= -(SW'(s1_pn_r[0]) + SW'(s1_pn_r[1]) + SW'(s1_pn_r[2]) + SW'(off_r));
      s2_den_r <= SW'(s1_rn_r[0]) + SW'(s1_rn_r[1]) + SW'(s1_rn_r[2]);
    end
  end

  // stage 3: sign fix and hit test
  logic s3_v_r, s3_hit_r, s3_one_r;
  logic signed [CW-1:0] s3_p_r [3];
  logic signed [DW-1:0] s3_d_r [3];
  spi_pkg::sum_t s3_num_r, s3_den_r;
  spi_pkg::sum_t fnum, fden;
  always_comb begin
    fnum = s2_den_r < 0 ? -s2_num_r : s2_num_r;
    fden = s2_den_r < 0 ? -s2_den_r : s2_den_r;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (advance) s3_v_r <= s2_v_r;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      s3_p_r   <= s2_p_r;
      s3_d_r   <= s2_d_r;
      s3_num_r <= fnum;
      s3_den_r <= fden;
      s3_hit_r <= (fden != 0) && (fnum >= 0) && (fnum <= fden);
      s3_one_r <= (fnum == fden);
    end
  end

  // divider: one quotient bit per stage, rem < den whenever hit and t < 1
  logic dv_v_r [ND];
  logic dv_hit_r [ND], dv_one_r [ND];
  logic signed [CW-1:0] dv_p_r [ND][3];
  logic signed [DW-1:0] dv_d_r [ND][3];
  spi_pkg::sum_t dv_rem_r [ND], dv_den_r [ND];
  logic [FB-1:0] dv_q_r [ND];

  for (genvar k = 0; k < ND; k++) begin : g_div
    spi_pkg::sum_t rem_in, den_in, rem2;
    logic [FB-1:0] q_in;
    logic v_in, hit_in, one_in;
    logic signed [CW-1:0] p_in [3];
    logic signed [DW-1:0] d_in [3];
    if (k == 0) begin : g_first
      assign rem_in = s3_num_r; assign den_in = s3_den_r; assign q_in = '0;
      assign v_in = s3_v_r; assign hit_in = s3_hit_r; assign one_in = s3_one_r;
      assign p_in = s3_p_r; assign d_in = s3_d_r;
    end else begin : g_rest
      assign rem_in = dv_rem_r[k-1]; assign den_in = dv_den_r[k-1];
      assign q_in = dv_q_r[k-1];
      assign v_in = dv_v_r[k-1]; assign hit_in = dv_hit_r[k-1];
      assign one_in = dv_one_r[k-1];
      assign p_in = dv_p_r[k-1]; assign d_in = dv_d_r[k-1];
    end
    assign rem2 = rem_in <<< 1;
    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[k] <= 1'b0;
      else if (advance) dv_v_r[k] <= v_in;
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        dv_den_r[k] <= den_in;
        dv_hit_r[k] <= hit_in;
        dv_one_r[k] <= one_in;
        dv_p_r[k]   <= p_in;
        dv_d_r[k]   <= d_in;
        // a miss or t=1 clears rem to zero; result is overridden later
        if (hit_in && !one_in && rem2 >= den_in) begin
          dv_rem_r[k] <= rem2 - den_in;
          dv_q_r[k]   <= {q_in[FB-2:0], 1'b1};
        end else begin
          dv_rem_r[k] <= (hit_in && !one_in) ? rem2 : '0;
          dv_q_r[k]   <= {q_in[FB-2:0], 1'b0};
        end
      end
    end
  end

  // point stage A: final fraction
  logic pa_v_r, pa_hit_r;
  logic [FW-1:0] pa_f_r;
  logic signed [CW-1:0] pa_p_r [3];
  logic signed [DW-1:0] pa_d_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) pa_v_r <= 1'b0;
    else if (advance) pa_v_r <= dv_v_r[ND-1];
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      pa_hit_r <= dv_hit_r[ND-1];
      pa_f_r   <= !dv_hit_r[ND-1] ? '0 :
                  dv_one_r[ND-1] ? FW'(65536) : {1'b0, dv_q_r[ND-1]};
      pa_p_r   <= dv_p_r[ND-1];
      pa_d_r   <= dv_d_r[ND-1];
    end
  end

  // point stage B: r * frac, floored
  logic pb_v_r, pb_hit_r;
  logic [FW-1:0] pb_f_r;
  logic signed [CW-1:0] pb_p_r [3];
  logic signed [MW-1:0] pb_m_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) pb_v_r <= 1'b0;
    else if (advance) pb_v_r <= pa_v_r;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      pb_hit_r <= pa_hit_r;
      pb_f_r   <= pa_f_r;
      pb_p_r   <= pa_p_r;
      for (int i = 0; i < 3; i++)
        pb_m_r[i] <= MW'((MW'(pa_d_r[i]) * $signed({1'b0, pa_f_r})) >>> FB);
    end
  end

  // point stage C: add start point
  logic pc_v_r, pc_hit_r;
  logic [FW-1:0] pc_f_r;
  logic signed [PTW-1:0] pc_s_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) pc_v_r <= 1'b0;
    else if (advance) pc_v_r <= pb_v_r;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      pc_hit_r <= pb_hit_r;
      pc_f_r   <= pb_f_r;
      for (int i = 0; i < 3; i++)
        pc_s_r[i] <= PTW'(pb_p_r[i]) + PTW'(pb_m_r[i]);
    end
  end

  // output register: saturate, zero on miss
  localparam logic signed [PTW-1:0] MAXV = PTW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [PTW-1:0] MINV = -MAXV - PTW'(1);
  logic signed [CW-1:0] sat [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!pc_hit_r)              sat[i] = '0;
      else if (pc_s_r[i] > MAXV)  sat[i] = MAXV[CW-1:0];
      else if (pc_s_r[i] < MINV)  sat[i] = MINV[CW-1:0];
      else                        sat[i] = pc_s_r[i][CW-1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (advance) out_valid <= pc_v_r;
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      out_hit      <= pc_hit_r;
      out_fraction <= pc_f_r;
      out_point_x  <= sat[0];
      out_point_y  <= sat[1];
      out_point_z  <= sat[2];
    end
  end

  `SPI_ASSERT_IMPL(a_ready_when_free, !out_valid, in_ready)
  `SPI_ASSERT_IMPL(a_miss_zero, out_valid && !out_hit, out_fraction == '0 && out_point_x == '0)
  `SPI_ASSERT_IMPL(a_frac_range, out_valid && out_hit, out_fraction <= FW'(65536))
  `SPI_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_fraction))
endmodule
